FILE: hw/rtl/scfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scfm_pkg;

   localparam int BUFFER_DEPTH = 16;
   // write index counts up to and including the depth
   localparam int IDX_W = $clog2(BUFFER_DEPTH + 1);
   localparam int POS_W = $clog2(BUFFER_DEPTH);
   // positions that take part in frame comparison
   localparam int CMP_LEN = 10;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_Q     = 8'h51;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_B     = 8'h42;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_STATUS = 2'd1;
   localparam logic [1:0] CMD_D_REQ  = 2'd2;
   localparam logic [1:0] CMD_B_REQ  = 2'd3;

   localparam logic [1:0] CSR_UNIT_ID_FIRST  = 2'd0;
   localparam logic [1:0] CSR_UNIT_ID_SECOND = 2'd1;
   localparam logic [1:0] CSR_UNIT_ID_THIRD  = 2'd2;

   localparam logic [7:0] UNIT_ID_FIRST_RST  = 8'd49;
   localparam logic [7:0] UNIT_ID_SECOND_RST = 8'd50;
   localparam logic [7:0] UNIT_ID_THIRD_RST  = 8'd52;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   typedef struct packed {
      logic [1:0] command;
      logic       byte_stored;
   } rsp_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] third;
   } unit_id_type;

   typedef logic [CMP_LEN-1:0][7:0] cmp_window_type;

endpackage

`default_nettype wire

FILE: hw/rtl/scfm_classify.sv
`timescale 1ns / 1ps
`default_nettype none

module scfm_classify (
   input  var scfm_pkg::cmp_window_type window,
   input  var scfm_pkg::unit_id_type    unit_id,
   output logic [1:0]                   command
);

   logic head_d;
   logic head_b;
   logic id_tail;

   assign head_d = window[0] == scfm_pkg::CH_STAR && window[1] == scfm_pkg::CH_HASH &&
                   window[2] == scfm_pkg::CH_D    && window[3] == scfm_pkg::CH_R &&
                   window[4] == scfm_pkg::CH_E    && window[5] == scfm_pkg::CH_Q;

   assign head_b = window[0] == scfm_pkg::CH_STAR && window[1] == scfm_pkg::CH_HASH &&
                   window[2] == scfm_pkg::CH_B    && window[3] == scfm_pkg::CH_R &&
                   window[4] == scfm_pkg::CH_E    && window[5] == scfm_pkg::CH_Q;

   assign id_tail = window[6] == scfm_pkg::CH_EQ && window[7] == unit_id.first &&
                    window[8] == unit_id.second && window[9] == unit_id.third;

   // first matching frame wins
   always_comb begin
      if (head_d && window[6] == scfm_pkg::CH_QMARK) begin
         command = scfm_pkg::CMD_STATUS;
      end else if (head_d && id_tail) begin
         command = scfm_pkg::CMD_D_REQ;
      end else if (head_b && id_tail) begin
         command = scfm_pkg::CMD_B_REQ;
      end else begin
         command = scfm_pkg::CMD_NONE;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/serial_command_frame_matcher.sv
// Serial command frame matcher.
// Request channel (req_valid / req_stall / req_payload) carries one received
// character with its error flag per transaction. A character with the error
// flag set is dropped and answered with command none, byte_stored 0. A good
// character is stored in a 16-byte frame buffer and the buffer head is
// compared with the status query, D request and B request frames; a match
// returns the command code and clears the buffer.
// Response channel (rsp_valid / rsp_stall / rsp_payload) returns exactly one
// result per request, in order.
// Order: a request enters the input register, then its result enters the
// result register. Throughput: one transaction per cycle unless rsp_stall.
// A stalled response holds; the input register keeps taking one more request
// and then raises req_stall until the response moves on.
// Configuration: csr_valid / csr_ready with csr_index and csr_data write the
// three unit id characters; csr_ready is always high, index 3 is ignored.
// Reset (synchronous, active high): buffer and write index cleared, unit id
// set to "124", both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_frame_matcher (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              req_valid,
   output logic                  req_stall,
   input  var scfm_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  var logic              rsp_stall,
   output scfm_pkg::rsp_type     rsp_payload,
   input  var logic              csr_valid,
   output logic                  csr_ready,
   input  var logic [1:0]        csr_index,
   input  var logic [7:0]        csr_data
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   scfm_pkg::req_type             s1_payload_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   scfm_pkg::rsp_type             rsp_payload_ff;
   scfm_pkg::rsp_type             rsp_payload_in;
   logic [scfm_pkg::BUFFER_DEPTH-1:0][7:0] frame_buffer_ff;
   logic [scfm_pkg::BUFFER_DEPTH-1:0][7:0] frame_buffer_in;
   logic [scfm_pkg::IDX_W-1:0]    write_index_ff;
   logic [scfm_pkg::IDX_W-1:0]    write_index_in;
   scfm_pkg::unit_id_type         unit_id_ff;

   logic                          advance;
   logic                          store;
   logic [scfm_pkg::POS_W-1:0]    wr_pos;
   scfm_pkg::cmp_window_type      window;
   logic [1:0]                    match_cmd;

   assign csr_ready   = 1'b1;
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign s1_valid_in  = (req_valid && !req_stall) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   assign store        = s1_valid_ff && advance && !s1_payload_ff.rx_error;

   // restart at the frame start character or when the buffer is full
   always_comb begin
      if (s1_payload_ff.rx_byte == scfm_pkg::CH_STAR ||
          write_index_ff >= scfm_pkg::IDX_W'(scfm_pkg::BUFFER_DEPTH)) begin
         wr_pos = '0;
      end else begin
         wr_pos = write_index_ff[scfm_pkg::POS_W-1:0];
      end
   end

   // buffer head as it stands after this character is written
   always_comb begin
      for (int k = 0; k < scfm_pkg::CMP_LEN; k++) begin
         window[k] = (wr_pos == scfm_pkg::POS_W'(k)) ? s1_payload_ff.rx_byte
                                                     : frame_buffer_ff[k];
      end
   end

   scfm_classify u_classify (
      .window  (window),
      .unit_id (unit_id_ff),
      .command (match_cmd)
   );

   always_comb begin
      frame_buffer_in = frame_buffer_ff;
      write_index_in  = write_index_ff;
      if (store) begin
         write_index_in = scfm_pkg::IDX_W'(wr_pos) + scfm_pkg::IDX_W'(1);
         if (match_cmd != scfm_pkg::CMD_NONE) begin
            frame_buffer_in = '0;
         end else begin
            frame_buffer_in[wr_pos] = s1_payload_ff.rx_byte;
         end
      end
   end

   always_comb begin
      rsp_payload_in.byte_stored = !s1_payload_ff.rx_error;
      rsp_payload_in.command     = s1_payload_ff.rx_error ? scfm_pkg::CMD_NONE : match_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         frame_buffer_ff <= '0;
         write_index_ff  <= '0;
         unit_id_ff      <= '{first:  scfm_pkg::UNIT_ID_FIRST_RST,
                              second: scfm_pkg::UNIT_ID_SECOND_RST,
                              third:  scfm_pkg::UNIT_ID_THIRD_RST};
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_buffer_ff <= frame_buffer_in;
         write_index_ff  <= write_index_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               scfm_pkg::CSR_UNIT_ID_FIRST:  unit_id_ff.first  <= csr_data;
               scfm_pkg::CSR_UNIT_ID_SECOND: unit_id_ff.second <= csr_data;
               scfm_pkg::CSR_UNIT_ID_THIRD:  unit_id_ff.third  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers: hold while the stage does not move
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_payload_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

`default_nettype wire
